// File: design/trvs_pkg.sv
`default_nettype none

package trvs_pkg;

	// Wide unsigned type for table construction at elaboration.
	typedef longint unsigned u64_t;

	// Field widths of the frame and vertex transactions.
	localparam int COORD_W     = 32;
	localparam int VEC_W       = 16;
	localparam int RADIUS_W    = 31;
	localparam int COLOR_W     = 32;
	localparam int RING_SLOT_W = 6;

	// Phase accumulator and configuration widths.
	localparam int PHASE_W    = 16;
	localparam int QUAD_LSB   = 14;
	localparam int STEP_W     = 15;
	localparam int DETAIL_W   = 7;
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 16;

	// Datapath widths: trig in Q1.14, radius times trig, vector products and the Q.44 sum.
	localparam int TRIG_W     = 16;
	localparam int ROM_W      = 15;
	localparam int RTRIG_W    = 46;
	localparam int PROD_W     = 62;
	localparam int SUM_W      = 63;
	localparam int POS_SHIFT  = 28;
	localparam int QUOT_W     = SUM_W - POS_SHIFT;
	localparam int CENTER_EXT = SUM_W - COORD_W - POS_SHIFT;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_RING_DETAIL = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP  = CFG_ADDR_W'(1);

	// Reset values and limits of the configuration registers.
	localparam logic [DETAIL_W-1:0] RING_DETAIL_RESET = DETAIL_W'(16);
	localparam logic [DETAIL_W-1:0] RING_DETAIL_MIN   = DETAIL_W'(3);
	localparam logic [STEP_W-1:0]   PHASE_STEP_RESET  = STEP_W'(4096);

	// Phase constants: a quarter turn and half of one table step in the index product.
	localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(16384);
	localparam int                 INDEX_HALF   = 8192;

	// Rounding offset for the Q.44 to Q16.16 conversion.
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd134217728);

	// Fixed-point constants for the sine table series.
	localparam u64_t Q30_ONE    = 64'd1073741824;
	localparam u64_t PIHALF_Q30 = 64'd1686629713;

	// One path frame as held by the ring sequencer.
	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic signed [VEC_W-1:0]   normal_x;
		logic signed [VEC_W-1:0]   normal_y;
		logic signed [VEC_W-1:0]   normal_z;
		logic signed [VEC_W-1:0]   binormal_x;
		logic signed [VEC_W-1:0]   binormal_y;
		logic signed [VEC_W-1:0]   binormal_z;
		logic [RADIUS_W-1:0]       radius;
		logic [COLOR_W-1:0]        color;
	} frame_t;

	// One issued vertex: its frame, its slot and the end-of-ring mark.
	typedef struct packed {
		frame_t                 frame;
		logic [RING_SLOT_W-1:0] slot;
		logic                   last;
	} issue_t;

	// Sine table entry for an angle in Q2.30 radians: Taylor series in Horner form,
	// rounded to Q1.14 and capped at one.
	function automatic logic [ROM_W-1:0] sine_entry(input u64_t ang);
		u64_t x2;
		u64_t t;
		u64_t s;
		u64_t q;
		x2 = (ang * ang) >> 30;
		t = Q30_ONE - x2 / 110;
		t = Q30_ONE - ((x2 * t) >> 30) / 72;
		t = Q30_ONE - ((x2 * t) >> 30) / 42;
		t = Q30_ONE - ((x2 * t) >> 30) / 20;
		t = Q30_ONE - ((x2 * t) >> 30) / 6;
		s = (ang * t) >> 30;
		q = (s + 64'd32768) >> 16;
		if (q > 64'd16384) begin
			q = 64'd16384;
		end
		return q[ROM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: design/trvs_ifs.sv
`default_nettype none

// Frame channel: one path frame per transaction.
interface trvs_frame_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [trvs_pkg::COORD_W-1:0]    center_x;
	logic signed [trvs_pkg::COORD_W-1:0]    center_y;
	logic signed [trvs_pkg::COORD_W-1:0]    center_z;
	logic signed [trvs_pkg::VEC_W-1:0]      normal_x;
	logic signed [trvs_pkg::VEC_W-1:0]      normal_y;
	logic signed [trvs_pkg::VEC_W-1:0]      normal_z;
	logic signed [trvs_pkg::VEC_W-1:0]      binormal_x;
	logic signed [trvs_pkg::VEC_W-1:0]      binormal_y;
	logic signed [trvs_pkg::VEC_W-1:0]      binormal_z;
	logic [trvs_pkg::RADIUS_W-1:0]          radius;
	logic [trvs_pkg::COLOR_W-1:0]           color_in;

	modport source (
		output valid, center_x, center_y, center_z, normal_x, normal_y, normal_z,
		       binormal_x, binormal_y, binormal_z, radius, color_in,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, center_z, normal_x, normal_y, normal_z,
		       binormal_x, binormal_y, binormal_z, radius, color_in,
		output ready
	);
endinterface

// Vertex channel: one ring vertex per transaction.
interface trvs_vertex_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [trvs_pkg::COORD_W-1:0]   pos_x;
	logic signed [trvs_pkg::COORD_W-1:0]   pos_y;
	logic signed [trvs_pkg::COORD_W-1:0]   pos_z;
	logic [trvs_pkg::COLOR_W-1:0]          color_out;
	logic [trvs_pkg::RING_SLOT_W-1:0]      ring_slot;
	logic                                  last_in_ring;

	modport source (
		output valid, pos_x, pos_y, pos_z, color_out, ring_slot, last_in_ring,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z, color_out, ring_slot, last_in_ring,
		output ready
	);
endinterface

// Configuration write channel: register index and write data.
interface trvs_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [trvs_pkg::CFG_ADDR_W-1:0]   addr;
	logic [trvs_pkg::CFG_DATA_W-1:0]   data;

	modport source (
		output valid, addr, data,
		input  ready
	);
	modport sink (
		input  valid, addr, data,
		output ready
	);
endinterface

`default_nettype wire

// File: design/trvs_ring_seq.sv
`default_nettype none

module trvs_ring_seq #(
	parameter int CNT_W = 6
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	trvs_frame_if.sink                              frame,
	input  wire logic [CNT_W-1:0]                   ring_last,
	input  wire logic [trvs_pkg::STEP_W-1:0]        phase_step,
	input  wire logic                               adv,
	output logic                                    v_s1,
	output trvs_pkg::issue_t                        issue_s1,
	output logic [trvs_pkg::PHASE_W-1:0]            phase_s1
);

	logic                              busy_q;
	logic [CNT_W-1:0]                  slot_q;
	logic [CNT_W-1:0]                  last_q;
	logic [trvs_pkg::PHASE_W-1:0]      phase_q;
	trvs_pkg::frame_t                  frame_q;
	logic                              at_last;
	logic                              accept;

	// A new frame is taken when idle or in the cycle its predecessor issues its last vertex.
	assign at_last     = (slot_q == last_q);
	assign frame.ready = !busy_q || (adv && at_last);
	assign accept      = frame.valid && frame.ready;

	// Ring control: slot counter and phase accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			slot_q  <= '0;
			last_q  <= '0;
			phase_q <= '0;
		end else begin
			if (busy_q && adv) begin
				slot_q  <= slot_q + 1'b1;
				phase_q <= phase_q + {1'b0, phase_step};
				if (at_last) begin
					busy_q <= 1'b0;
				end
			end
			if (accept) begin
				busy_q  <= 1'b1;
				slot_q  <= '0;
				phase_q <= '0;
				last_q  <= ring_last;
			end
		end
	end

	// Frame holding register.
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= '{
				center_x:   frame.center_x,
				center_y:   frame.center_y,
				center_z:   frame.center_z,
				normal_x:   frame.normal_x,
				normal_y:   frame.normal_y,
				normal_z:   frame.normal_z,
				binormal_x: frame.binormal_x,
				binormal_y: frame.binormal_y,
				binormal_z: frame.binormal_z,
				radius:     frame.radius,
				color:      frame.color_in
			};
		end
	end

	// Issue stage: one vertex per advancing cycle while a frame is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			issue_s1 <= '{frame: frame_q, slot: trvs_pkg::RING_SLOT_W'(slot_q), last: at_last};
			phase_s1 <= phase_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> slot_q <= last_q)
		else $error("ring slot counter passed the last slot");

	a_ring_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && slot_q == '0 && phase_q == '0)
		else $error("accepted frame did not start a fresh ring");
`endif

endmodule

`default_nettype wire

// File: design/trvs_sine_lut.sv
`default_nettype none

module trvs_sine_lut #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                adv,
	input  wire logic [trvs_pkg::PHASE_W-1:0]        phase_s1,
	output logic signed [trvs_pkg::TRIG_W-1:0]       sin_s3,
	output logic signed [trvs_pkg::TRIG_W-1:0]       cos_s3
);

	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW = trvs_pkg::QUAD_LSB + AW;

	logic [trvs_pkg::ROM_W-1:0]             rom [SINE_TABLE_DEPTH+1];
	logic [trvs_pkg::PHASE_W-1:0]           ph_w   [2];
	logic [PW-1:0]                          prod_w [2];
	logic [AW-1:0]                          idx_w  [2];
	logic [AW-1:0]                          addr_w [2];
	logic [AW-1:0]                          addr_s2 [2];
	logic                                   neg_s2  [2];
	logic signed [trvs_pkg::TRIG_W-1:0]     mag_w   [2];
	logic signed [trvs_pkg::TRIG_W-1:0]     trig_s3 [2];

	// Quarter-wave table, built from constants at elaboration.
	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam trvs_pkg::u64_t ANG =
			(trvs_pkg::u64_t'(k) * trvs_pkg::PIHALF_Q30) / SINE_TABLE_DEPTH;
		assign rom[k] = trvs_pkg::sine_entry(ANG);
	end

	// Lane 0 is sine, lane 1 is cosine (a quarter turn ahead).
	assign ph_w[0] = phase_s1;
	assign ph_w[1] = phase_s1 + trvs_pkg::QUARTER_TURN;

	// Table index from the phase within its quadrant, mirrored in odd quadrants.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			prod_w[l] = PW'(ph_w[l][trvs_pkg::QUAD_LSB-1:0]) * PW'(SINE_TABLE_DEPTH)
			            + PW'(trvs_pkg::INDEX_HALF);
			idx_w[l]  = prod_w[l][PW-1:trvs_pkg::QUAD_LSB];
			addr_w[l] = ph_w[l][trvs_pkg::QUAD_LSB] ? AW'(SINE_TABLE_DEPTH) - idx_w[l]
			                                        : idx_w[l];
		end
	end

	// Table read of the magnitude; the sign of the lower half turn is applied in the output stage.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag_w[l] = $signed({1'b0, rom[addr_s2[l]]});
		end
	end

	// Index stage and table output stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				addr_s2[l] <= addr_w[l];
				neg_s2[l]  <= ph_w[l][trvs_pkg::PHASE_W-1];
				trig_s3[l] <= neg_s2[l] ? -mag_w[l] : mag_w[l];
			end
		end
	end

	assign sin_s3 = trig_s3[0];
	assign cos_s3 = trig_s3[1];

endmodule

`default_nettype wire

// File: design/trvs_vertex_pipe.sv
`default_nettype none

module trvs_vertex_pipe (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                v_s1,
	input  wire trvs_pkg::issue_t                    issue_s1,
	input  wire logic signed [trvs_pkg::TRIG_W-1:0]  sin_s3,
	input  wire logic signed [trvs_pkg::TRIG_W-1:0]  cos_s3,
	output logic                                     adv,
	trvs_vertex_if.source                            vertex
);

	logic                                       v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	trvs_pkg::issue_t                           issue_s2, issue_s3, issue_s4, issue_s5;
	logic signed [trvs_pkg::COORD_W-1:0]        r_w;
	logic signed [trvs_pkg::RTRIG_W-1:0]        rc_s4, rs_s4;
	logic signed [trvs_pkg::VEC_W-1:0]          n_w [3];
	logic signed [trvs_pkg::VEC_W-1:0]          b_w [3];
	logic signed [trvs_pkg::COORD_W-1:0]        c_w [3];
	logic signed [trvs_pkg::SUM_W-1:0]          cen_w [3];
	logic signed [trvs_pkg::PROD_W-1:0]         pn_s5 [3];
	logic signed [trvs_pkg::PROD_W-1:0]         pb_s5 [3];
	logic signed [trvs_pkg::SUM_W-1:0]          sum_s6 [3];
	logic [trvs_pkg::QUOT_W-1:0]                quot_w [3];
	logic [trvs_pkg::COORD_W-1:0]               sat_w [3];
	logic [trvs_pkg::COORD_W-1:0]               pos_s7 [3];
	logic [trvs_pkg::COLOR_W-1:0]               color_s6, color_s7;
	logic [trvs_pkg::RING_SLOT_W-1:0]           slot_s6, slot_s7;
	logic                                       last_s6, last_s7;

	// The whole pipeline moves unless the output register holds an untaken vertex.
	assign adv = !v_s7 || vertex.ready;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else if (adv) begin
			{v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= {v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	// Per-axis views of the frame vectors.
	assign r_w = $signed({1'b0, issue_s3.frame.radius});
	assign n_w[0] = issue_s4.frame.normal_x;
	assign n_w[1] = issue_s4.frame.normal_y;
	assign n_w[2] = issue_s4.frame.normal_z;
	assign b_w[0] = issue_s4.frame.binormal_x;
	assign b_w[1] = issue_s4.frame.binormal_y;
	assign b_w[2] = issue_s4.frame.binormal_z;
	assign c_w[0] = issue_s5.frame.center_x;
	assign c_w[1] = issue_s5.frame.center_y;
	assign c_w[2] = issue_s5.frame.center_z;

	// Center scaled to Q.44, and the floor to Q16.16 with saturation.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cen_w[a]  = $signed({{trvs_pkg::CENTER_EXT{c_w[a][trvs_pkg::COORD_W-1]}},
			                     c_w[a], {trvs_pkg::POS_SHIFT{1'b0}}});
			quot_w[a] = sum_s6[a][trvs_pkg::SUM_W-1:trvs_pkg::POS_SHIFT];
			if (quot_w[a][trvs_pkg::QUOT_W-1:trvs_pkg::COORD_W-1] == '0 ||
			    quot_w[a][trvs_pkg::QUOT_W-1:trvs_pkg::COORD_W-1] == '1) begin
				sat_w[a] = quot_w[a][trvs_pkg::COORD_W-1:0];
			end else if (quot_w[a][trvs_pkg::QUOT_W-1]) begin
				sat_w[a] = {1'b1, {(trvs_pkg::COORD_W-1){1'b0}}};
			end else begin
				sat_w[a] = {1'b0, {(trvs_pkg::COORD_W-1){1'b1}}};
			end
		end
	end

	// Stages: side data, radius times trig, vector products, sum, saturated output.
	always_ff @(posedge clk) begin
		if (adv) begin
			issue_s2 <= issue_s1;
			issue_s3 <= issue_s2;
			issue_s4 <= issue_s3;
			issue_s5 <= issue_s4;

			rc_s4 <= trvs_pkg::RTRIG_W'(r_w) * trvs_pkg::RTRIG_W'(cos_s3);
			rs_s4 <= trvs_pkg::RTRIG_W'(r_w) * trvs_pkg::RTRIG_W'(sin_s3);

			for (int a = 0; a < 3; a++) begin
				pn_s5[a]  <= trvs_pkg::PROD_W'(rc_s4) * trvs_pkg::PROD_W'(n_w[a]);
				pb_s5[a]  <= trvs_pkg::PROD_W'(rs_s4) * trvs_pkg::PROD_W'(b_w[a]);
				sum_s6[a] <= cen_w[a] + trvs_pkg::SUM_W'(pn_s5[a]) + trvs_pkg::SUM_W'(pb_s5[a])
				             + trvs_pkg::ROUND_HALF;
				pos_s7[a] <= sat_w[a];
			end

			color_s6 <= issue_s5.frame.color;
			slot_s6  <= issue_s5.slot;
			last_s6  <= issue_s5.last;
			color_s7 <= color_s6;
			slot_s7  <= slot_s6;
			last_s7  <= last_s6;
		end
	end

	// Output register drives the vertex channel.
	assign vertex.valid        = v_s7;
	assign vertex.pos_x        = pos_s7[0];
	assign vertex.pos_y        = pos_s7[1];
	assign vertex.pos_z        = pos_s7[2];
	assign vertex.color_out    = color_s7;
	assign vertex.ring_slot    = slot_s7;
	assign vertex.last_in_ring = last_s7;

`ifndef NO_ASSERTIONS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s2, v_s3, v_s4, v_s5, v_s6, v_s7}))
		else $error("pipeline valid bits changed during a stall");
`endif

endmodule

`default_nettype wire

// File: design/tube_ring_vertex_sweep_top.sv
`default_nettype none

// Tube ring vertex generator. Each frame transaction (center, unit normal and binormal,
// radius, color) produces one cross-section ring of vertices, center + r*cos*N + r*sin*B,
// with the angle stepped by phase_step from zero, coordinates rounded and saturated to
// signed Q16.16, the color copied and the final vertex marked. A frame occupies the ring
// sequencer for ring_detail vertices (16 at reset, clamped to 3..MAX_RING_DETAIL), one
// vertex per cycle while the vertex channel does not stall; the next frame is taken in
// the cycle the current one issues its last vertex. After it issues, a vertex passes
// through table index, table read, radius multiply, vector multiply, sum and saturation,
// each one register stage, and a stall on the vertex channel holds the whole pipeline.
// The sine table is constant, so the block is ready right after reset.
// Configuration writes are taken at any time but belong only in idle periods.
module tube_ring_vertex_sweep_top #(
	parameter int MAX_RING_DETAIL  = 64,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	trvs_frame_if.sink      frame,
	trvs_vertex_if.source   vertex,
	trvs_cfg_if.sink        cfg
);

	localparam int CNT_W = $clog2(MAX_RING_DETAIL);

	logic [trvs_pkg::DETAIL_W-1:0]    ring_detail_q;
	logic [trvs_pkg::STEP_W-1:0]      phase_step_q;
	logic [trvs_pkg::DETAIL_W-1:0]    detail_eff;
	logic [CNT_W-1:0]                 ring_last;
	logic                             adv;
	logic                             v_s1;
	trvs_pkg::issue_t                 issue_s1;
	logic [trvs_pkg::PHASE_W-1:0]     phase_s1;
	logic signed [trvs_pkg::TRIG_W-1:0] sin_s3, cos_s3;

	// Configuration registers; unknown indexes are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_detail_q <= trvs_pkg::RING_DETAIL_RESET;
			phase_step_q  <= trvs_pkg::PHASE_STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.addr)
				trvs_pkg::REG_RING_DETAIL: ring_detail_q <= cfg.data[trvs_pkg::DETAIL_W-1:0];
				trvs_pkg::REG_PHASE_STEP:  phase_step_q  <= cfg.data[trvs_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Ring size clamped to the supported range, then turned into the last slot index.
	always_comb begin
		priority if (ring_detail_q < trvs_pkg::RING_DETAIL_MIN) begin
			detail_eff = trvs_pkg::RING_DETAIL_MIN;
		end else if (ring_detail_q > trvs_pkg::DETAIL_W'(MAX_RING_DETAIL)) begin
			detail_eff = trvs_pkg::DETAIL_W'(MAX_RING_DETAIL);
		end else begin
			detail_eff = ring_detail_q;
		end
		ring_last = CNT_W'(detail_eff - 1'b1);
	end

	trvs_ring_seq #(
		.CNT_W (CNT_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.ring_last  (ring_last),
		.phase_step (phase_step_q),
		.adv        (adv),
		.v_s1       (v_s1),
		.issue_s1   (issue_s1),
		.phase_s1   (phase_s1)
	);

	trvs_sine_lut #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_lut (
		.clk      (clk),
		.adv      (adv),
		.phase_s1 (phase_s1),
		.sin_s3   (sin_s3),
		.cos_s3   (cos_s3)
	);

	trvs_vertex_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s1     (v_s1),
		.issue_s1 (issue_s1),
		.sin_s3   (sin_s3),
		.cos_s3   (cos_s3),
		.adv      (adv),
		.vertex   (vertex)
	);

`ifndef NO_ASSERTIONS
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && vertex.last_in_ring |->
			vertex.ring_slot == trvs_pkg::RING_SLOT_W'(ring_last))
		else $error("end-of-ring mark on a vertex that is not the last slot");
`endif

endmodule

`default_nettype wire
